>>> rtl/bcp_pkg.sv
// ============================================================================
// bcp_pkg: shared types and constants for the binomial coefficient block
// Holds the field widths, the controller states and the command and status
// groups that pass between the controller and the datapath.
// ============================================================================
package bcp_pkg;

    // Widths of the stream fields.
    localparam int unsigned NUM_W     = 7;
    localparam int unsigned COEF_W    = 64;
    localparam int unsigned IN_DATA_W = 16;

    // Default largest row of the triangle.
    localparam int unsigned MAX_N_DEFAULT = 64;

    // Controller states.
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_BUILD
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;       // Capture a request and seed row zero.
        logic step;        // Advance the triangle by one row.
        logic load_row;    // Move the selected cell into the output register.
        logic load_const;  // Move the trivial-case value into the output register.
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic trivial;     // The offered request needs no triangle.
        logic row_done;    // The triangle has reached row n.
    } status_t;

endpackage

>>> rtl/bcp_ctrl.sv
// ============================================================================
// bcp_ctrl: controller for the binomial coefficient block
// Sequences request capture, row building and result delivery, and owns
// the handshake on both stream sides.
// ============================================================================
module bcp_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  bcp_pkg::status_t status,
    output bcp_pkg::cmd_t    cmd
);

    bcp_pkg::state_t state_reg;
    bcp_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;
    logic            accept;

    // The output register can take a new result when empty or being drained.
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == bcp_pkg::ST_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bcp_pkg::ST_IDLE:
            begin
                if (accept && !status.trivial)
                begin
                    state_next = bcp_pkg::ST_BUILD;
                end
            end
            bcp_pkg::ST_BUILD:
            begin
                if (status.row_done && out_free)
                begin
                    state_next = bcp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bcp_pkg::ST_IDLE;
            end
        endcase
    end

    // Output logic: datapath commands and the output valid flag.
    always_comb
    begin
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            bcp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (status.trivial)
                    begin
                        cmd.load_const = 1'b1;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        cmd.start = 1'b1;
                    end
                end
            end
            bcp_pkg::ST_BUILD:
            begin
                if (!status.row_done)
                begin
                    cmd.step = 1'b1;
                end
                else if (out_free)
                begin
                    cmd.load_row   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bcp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/bcp_datapath.sv
// ============================================================================
// bcp_datapath: Pascal row cells and result register
// A row of MAX_N+1 cells applies Pascal's rule to every cell at once, so the
// triangle advances one row per step command.
// ============================================================================
module bcp_datapath
#(
    parameter int unsigned MAX_N = bcp_pkg::MAX_N_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [bcp_pkg::NUM_W-1:0]    n,
    input  logic [bcp_pkg::NUM_W-1:0]    k,
    input  bcp_pkg::cmd_t                cmd,
    output bcp_pkg::status_t             status,
    output logic [bcp_pkg::COEF_W-1:0]   coefficient
);

    localparam int unsigned DEPTH = MAX_N + 1;
    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam logic [bcp_pkg::NUM_W-1:0] MAX_N_V = bcp_pkg::NUM_W'(MAX_N);
    localparam logic [bcp_pkg::NUM_W-1:0] ONE_V   = bcp_pkg::NUM_W'(1);

    logic [bcp_pkg::COEF_W-1:0] cell_reg [DEPTH];
    logic [bcp_pkg::NUM_W-1:0]  n_reg;
    logic [bcp_pkg::NUM_W-1:0]  k_reg;
    logic [bcp_pkg::NUM_W-1:0]  row_reg;
    logic [bcp_pkg::NUM_W-1:0]  row_next;
    logic [bcp_pkg::NUM_W-1:0]  k_mirror;
    logic [bcp_pkg::COEF_W-1:0] const_value;
    logic [bcp_pkg::COEF_W-1:0] coef_reg;
    logic                       degenerate;
    logic                       too_large;

    // Classify the offered request.
    assign degenerate     = (n <= ONE_V) || (k == '0) || (k >= n);
    assign too_large      = n > MAX_N_V;
    assign status.trivial = degenerate || too_large;
    assign const_value    = (!degenerate && too_large) ? '0 : bcp_pkg::COEF_W'(1);

    // Fold k onto the lower half of the row.
    assign k_mirror = (k > (n >> 1)) ? (n - k) : k;

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            n_reg <= n;
            k_reg <= k_mirror;
        end
    end

    // Row counter: index of the row now held in the cells.
    always_comb
    begin
        row_next = row_reg;
        if (cmd.start)
        begin
            row_next = '0;
        end
        else if (cmd.step)
        begin
            row_next = row_reg + ONE_V;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    assign status.row_done = (row_reg == n_reg);

    // Cell zero is always one once a request starts.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cell_reg[0] <= bcp_pkg::COEF_W'(1);
        end
    end

    // Remaining cells start at zero and add their left neighbor on each step;
    // cells beyond the current row stay zero.
    for (genvar j = 1; j < DEPTH; j++)
    begin : g_cell
        always_ff @(posedge clk)
        begin
            if (cmd.start)
            begin
                cell_reg[j] <= '0;
            end
            else if (cmd.step)
            begin
                cell_reg[j] <= cell_reg[j] + cell_reg[j-1];
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_row)
        begin
            coef_reg <= cell_reg[k_reg[IDX_W-1:0]];
        end
        else if (cmd.load_const)
        begin
            coef_reg <= const_value;
        end
    end

    assign coefficient = coef_reg;

endmodule

>>> rtl/binomial_coefficient_pascal.sv
// ============================================================================
// binomial_coefficient_pascal: C(n,k) by Pascal's triangle
// A trivial request (n <= 1, k == 0, k >= n, or n above MAX_N) is answered
// in the cycle after its transfer. Any other request builds the triangle in
// the cell row at one triangle row per cycle, and its result is loaded once
// row n is reached and the output register is free; no new request is taken before that load.
// A new request is taken only while the output register is empty or drains.
// rst_n clears the controller, the output valid flag and the row counter.
// ============================================================================
module binomial_coefficient_pascal
#(
    parameter int unsigned MAX_N = bcp_pkg::MAX_N_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0: n [6:0], k [13:7], zero fill [15:14].
    input  logic [bcp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Fields from bit 0: coefficient [63:0].
    output logic [bcp_pkg::COEF_W-1:0]     m_axis_tdata
);

    bcp_pkg::cmd_t    cmd;
    bcp_pkg::status_t status;

    // Controller.
    bcp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath.
    bcp_datapath #(
        .MAX_N (MAX_N)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .n           (s_axis_tdata[bcp_pkg::NUM_W-1:0]),
        .k           (s_axis_tdata[2*bcp_pkg::NUM_W-1:bcp_pkg::NUM_W]),
        .cmd         (cmd),
        .status      (status),
        .coefficient (m_axis_tdata)
    );

endmodule
